// ===== rtl/core/hrs_pkg.sv =====
// Shared types, constants and orientation tables of the Hilbert rectangle scan generator.
`default_nettype none

package hrs_pkg;

  // Default log2 of the largest rectangle side
  localparam int unsigned MAX_DIM_LOG2_DEF = 10;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;

  // Orientation and quadrant codes
  localparam int unsigned ORIENT_W = 2;
  localparam int unsigned CHILD_W  = 3;   // holds 0..4, 4 = all children visited
  localparam logic [ORIENT_W-1:0] ORIENT_ROOT = 2'd0;
  localparam logic [CHILD_W-1:0]  CHILD_FIRST = 3'd0;

  // Quadrant code: bit 0 = right half, bit 1 = bottom half
  localparam logic [1:0] QUAD_TL = 2'd0;
  localparam logic [1:0] QUAD_TR = 2'd1;
  localparam logic [1:0] QUAD_BL = 2'd2;
  localparam logic [1:0] QUAD_BR = 2'd3;

  // Visiting order of the quadrants for each orientation
  localparam logic [1:0] QUAD_TAB [4][4] = '{
    '{QUAD_TL, QUAD_BL, QUAD_BR, QUAD_TR},
    '{QUAD_BR, QUAD_BL, QUAD_TL, QUAD_TR},
    '{QUAD_BR, QUAD_TR, QUAD_TL, QUAD_BL},
    '{QUAD_TL, QUAD_TR, QUAD_BR, QUAD_BL}
  };

  // Orientation handed to each visited child
  localparam logic [ORIENT_W-1:0] ORIENT_TAB [4][4] = '{
    '{2'd3, 2'd0, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd1, 2'd0},
    '{2'd1, 2'd2, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd3, 2'd2}
  };

  // Controller to datapath
  typedef struct packed {
    logic load_root;   // reload the root region from the size registers
    logic step;        // perform one traversal step
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;        // the current step yields an item (point or end mark)
    logic out_free;    // output register can take an item this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/hilbert_rectangle_scan_generator.sv =====
// Top level of the Hilbert rectangle scan generator.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   restart
//   out      output     out_valid / out_stall point_x, point_y, at_end
//   cfg      input      cfg_en                cfg_index, cfg_data
//
// A request is accepted first, then the walk takes one traversal step per cycle
// (descend into a quadrant, climb one level, or issue the item); a step that
// issues an item waits for a free output register. A point takes more steps
// where the walk climbs and descends past empty quadrants.
// Synchronous reset loads a 1024 by 1024 rectangle, capped at the largest side;
// no restart is needed first.
// A full output register holds the walk until out_stall drops.
`default_nettype none

module hilbert_rectangle_scan_generator #(
  parameter int unsigned MAX_DIM_LOG2 = hrs_pkg::MAX_DIM_LOG2_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_en,
  input  wire logic [hrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           restart,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [MAX_DIM_LOG2-1:0]             point_x,
  output logic [MAX_DIM_LOG2-1:0]             point_y,
  output logic                                at_end
);

  hrs_pkg::cmd_t cmd;
  hrs_pkg::sts_t sts;

  hrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .restart  (restart),
    .sts      (sts),
    .cmd      (cmd)
  );

  hrs_datapath #(
    .MAX_DIM_LOG2 (MAX_DIM_LOG2)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .at_end    (at_end)
  );

endmodule

`default_nettype wire

// ===== rtl/core/hrs_ctrl.sv =====
// Sequencing state machine: accepts a request, then steps the traversal until an item is issued.
`default_nettype none

module hrs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          restart,
  input  wire hrs_pkg::sts_t sts,
  output hrs_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  // Commands: stall the walk while a result waits for a full output register
  always_comb begin
    cmd.load_root = accept && restart;
    cmd.step      = (state == ST_WALK) && (!sts.emit || sts.out_free);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (sts.emit && sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hrs_datapath.sv =====
// Traversal stack, size registers, one-step walk logic and output register.
`default_nettype none

module hrs_datapath #(
  parameter int unsigned MAX_DIM_LOG2 = hrs_pkg::MAX_DIM_LOG2_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_en,
  input  wire logic [hrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire hrs_pkg::cmd_t                  cmd,
  output hrs_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [MAX_DIM_LOG2-1:0]             point_x,
  output logic [MAX_DIM_LOG2-1:0]             point_y,
  output logic                                at_end
);

  localparam int unsigned CW      = MAX_DIM_LOG2 + 1;
  localparam int unsigned LEVELS  = MAX_DIM_LOG2 + 1;
  localparam int unsigned DEPTH_W = $clog2(LEVELS);
  localparam int unsigned MAX_DIM = 1 << MAX_DIM_LOG2;
  localparam int unsigned RST_DIM = (1024 > MAX_DIM) ? MAX_DIM : 1024;
  localparam logic [DEPTH_W-1:0] TOP_LEVEL = DEPTH_W'(LEVELS - 1);

  // Size registers
  logic [CW-1:0] rect_height;
  logic [CW-1:0] rect_width;
  logic [CW-1:0] cfg_dim;

  // Traversal stack, one level per entry
  logic [CW-1:0]                   yi_s [LEVELS];
  logic [CW-1:0]                   yj_s [LEVELS];
  logic [CW-1:0]                   xi_s [LEVELS];
  logic [CW-1:0]                   xj_s [LEVELS];
  logic [hrs_pkg::ORIENT_W-1:0]    orient_s [LEVELS];
  logic [hrs_pkg::CHILD_W-1:0]     child_s [LEVELS];
  logic [DEPTH_W-1:0]              stack_depth;
  logic                            finished;

  // Walk signals
  logic [CW-1:0]                   top_yi, top_yj, top_xi, top_xj;
  logic [hrs_pkg::ORIENT_W-1:0]    top_orient;
  logic [hrs_pkg::CHILD_W-1:0]     top_child;
  logic [CW-1:0]                   h, w, my, mx;
  logic [CW-1:0]                   c_yi, c_yj, c_xi, c_xj;
  logic [1:0]                      quad;
  logic [hrs_pkg::ORIENT_W-1:0]    c_orient;
  logic [DEPTH_W-1:0]              depth_inc;
  logic                            is_empty, is_unit, is_done;
  logic                            emit, do_pop, do_desc, can_push;

  // Saturate a written size to the largest side
  always_comb begin
    if (32'(cfg_data) > 32'(MAX_DIM)) begin
      cfg_dim = CW'(MAX_DIM);
    end else begin
      cfg_dim = CW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_height <= CW'(RST_DIM);
      rect_width  <= CW'(RST_DIM);
    end else if (cfg_en) begin
      if (cfg_index == hrs_pkg::REG_HEIGHT) rect_height <= cfg_dim;
      if (cfg_index == hrs_pkg::REG_WIDTH)  rect_width  <= cfg_dim;
    end
  end

  // Read the top level
  assign top_yi     = yi_s[stack_depth];
  assign top_yj     = yj_s[stack_depth];
  assign top_xi     = xi_s[stack_depth];
  assign top_xj     = xj_s[stack_depth];
  assign top_orient = orient_s[stack_depth];
  assign top_child  = child_s[stack_depth];

  // Classify the top region and pick the next child
  always_comb begin
    h         = top_yj - top_yi;
    w         = top_xj - top_xi;
    my        = top_yi + (h >> 1);
    mx        = top_xi + (w >> 1);
    is_empty  = (h == '0) || (w == '0);
    is_unit   = (h == CW'(1)) && (w == CW'(1));
    is_done   = top_child[2];
    emit      = finished || (!is_empty && is_unit);
    do_pop    = !finished && (is_empty || is_unit || is_done);
    do_desc   = !finished && !is_empty && !is_unit && !is_done;
    quad      = hrs_pkg::QUAD_TAB[top_orient][top_child[1:0]];
    c_orient  = hrs_pkg::ORIENT_TAB[top_orient][top_child[1:0]];
    c_yi      = quad[1] ? my : top_yi;
    c_yj      = quad[1] ? top_yj : my;
    c_xi      = quad[0] ? mx : top_xi;
    c_xj      = quad[0] ? top_xj : mx;
    depth_inc = stack_depth + 1'b1;
    can_push  = (stack_depth != TOP_LEVEL);
  end

  assign sts.emit     = emit;
  assign sts.out_free = !out_valid || !out_stall;

  // Stack storage: root reload, child advance and push
  always_ff @(posedge clk) begin
    if (rst || cmd.load_root) begin
      yi_s[0]     <= '0;
      yj_s[0]     <= rst ? CW'(RST_DIM) : rect_height;
      xi_s[0]     <= '0;
      xj_s[0]     <= rst ? CW'(RST_DIM) : rect_width;
      orient_s[0] <= hrs_pkg::ORIENT_ROOT;
      child_s[0]  <= hrs_pkg::CHILD_FIRST;
    end else if (cmd.step && do_desc) begin
      child_s[stack_depth] <= top_child + 1'b1;
      if (can_push) begin
        yi_s[depth_inc]     <= c_yi;
        yj_s[depth_inc]     <= c_yj;
        xi_s[depth_inc]     <= c_xi;
        xj_s[depth_inc]     <= c_xj;
        orient_s[depth_inc] <= c_orient;
        child_s[depth_inc]  <= hrs_pkg::CHILD_FIRST;
      end
    end
  end

  // Depth and end flag
  always_ff @(posedge clk) begin
    if (rst || cmd.load_root) begin
      stack_depth <= '0;
      finished    <= 1'b0;
    end else if (cmd.step) begin
      if (do_pop) begin
        if (stack_depth == '0) finished <= 1'b1;
        else stack_depth <= stack_depth - 1'b1;
      end else if (do_desc && can_push) begin
        stack_depth <= depth_inc;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      point_x <= finished ? '0 : top_xi[MAX_DIM_LOG2-1:0];
      point_y <= finished ? '0 : top_yi[MAX_DIM_LOG2-1:0];
      at_end  <= finished;
    end
  end

endmodule

`default_nettype wire
